>>> hw/rtl/assert_macros.svh
// Assertion macros for the relay sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define BRCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("relay sequencer check failed");

// Next-cycle implication, checked on aclk outside reset.
`define BRCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("relay sequencer check failed");

`endif

>>> hw/rtl/brcs_pkg.sv
// Types and constants for the battery relay close sequencer.
package brcs_pkg;

    localparam int DELAY_W = 16;
    localparam int MODE_W  = 2;
    localparam int STEP_W  = 2;
    localparam int EN_W    = 3;

    localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FAULT  = 2'd2;

    localparam logic [STEP_W-1:0] STEP_NONE     = 2'd0;
    localparam logic [STEP_W-1:0] STEP_POSITIVE = 2'd1;
    localparam logic [STEP_W-1:0] STEP_NEGATIVE = 2'd2;
    localparam logic [STEP_W-1:0] STEP_SOLAR    = 2'd3;

    localparam logic [EN_W-1:0] EN_POSITIVE = 3'b001;
    localparam logic [EN_W-1:0] EN_NEGATIVE = 3'b010;
    localparam logic [EN_W-1:0] EN_SOLAR    = 3'b100;

    localparam logic [DELAY_W-1:0] CLOSE_STEP_DELAY_RESET = 16'd150;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STEP_W-1:0]  close_step;
        logic [DELAY_W-1:0] delay_count;
        logic [EN_W-1:0]    enables;
    } brcs_state_t;

endpackage

>>> hw/rtl/brcs_step.sv
// Next-state logic for one tick of the relay sequencer.
module brcs_step
    import brcs_pkg::*;
(
    input  brcs_state_t        cur_state,
    input  logic [DELAY_W-1:0] close_step_delay,
    input  logic               fault_present,
    input  logic               close_request,
    output brcs_state_t        next_state
);

    logic [DELAY_W-1:0] load_value;
    logic [DELAY_W-1:0] count_dec;

    // A zero delay behaves as one tick.
    assign load_value = (close_step_delay == '0) ? DELAY_W'(1) : close_step_delay;
    assign count_dec  = cur_state.delay_count - DELAY_W'(1);

    always_comb begin
        next_state = cur_state;
        if (cur_state.mode == MODE_FAULT || fault_present) begin
            next_state.mode        = MODE_FAULT;
            next_state.enables     = '0;
            next_state.close_step  = STEP_NONE;
            next_state.delay_count = '0;
        end else if (cur_state.mode == MODE_OPEN) begin
            if (close_request) begin
                next_state.mode        = MODE_CLOSED;
                next_state.close_step  = STEP_NONE;
                next_state.delay_count = load_value;
            end
        end else if (!close_request) begin
            // Open cancels any pending step.
            next_state.mode        = MODE_OPEN;
            next_state.enables     = '0;
            next_state.close_step  = STEP_NONE;
            next_state.delay_count = '0;
        end else if (cur_state.delay_count != '0) begin
            next_state.delay_count = count_dec;
            if (count_dec == '0) begin
                case (cur_state.close_step)
                    STEP_NONE: begin
                        next_state.enables     = cur_state.enables | EN_POSITIVE;
                        next_state.close_step  = STEP_POSITIVE;
                        next_state.delay_count = load_value;
                    end
                    STEP_POSITIVE: begin
                        next_state.enables     = cur_state.enables | EN_NEGATIVE;
                        next_state.close_step  = STEP_NEGATIVE;
                        next_state.delay_count = load_value;
                    end
                    STEP_NEGATIVE: begin
                        next_state.enables     = cur_state.enables | EN_SOLAR;
                        next_state.close_step  = STEP_SOLAR;
                        next_state.delay_count = '0;
                    end
                    default: begin
                        next_state.delay_count = '0;
                    end
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/battery_relay_close_sequencer_unit.sv
// Battery relay close sequencer: the result is valid in the cycle after input accept.
// Throughput one item per cycle while results are taken; the state registers and
// result register both load on the same accept edge. The input stalls only while
// the result register is full and the result is not taken in that cycle.
// Synchronous active-low reset: mode open, no step pending, all relays open,
// close_step_delay back to 150 ticks, result register empty.
module battery_relay_close_sequencer_unit
    import brcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DELAY_W-1:0] cfg_close_step_delay,
    // tick input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_fault_present,
    input  logic               s_close_request,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_positive_enable,
    output logic               m_negative_enable,
    output logic               m_solar_enable,
    output logic [MODE_W-1:0]  m_relay_mode
);

`include "assert_macros.svh"

    logic [DELAY_W-1:0] close_step_delay_reg;
    brcs_state_t        state_reg;
    brcs_state_t        state_next;
    logic               m_valid_reg;
    logic [EN_W-1:0]    m_enables_reg;
    logic [MODE_W-1:0]  m_mode_reg;
    logic               s_accept;

    // The configuration register is always writable.
    assign cfg_ready = 1'b1;

    // Take a new item whenever the result slot is empty or draining this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_step_delay_reg <= CLOSE_STEP_DELAY_RESET;
        end else if (cfg_valid) begin
            close_step_delay_reg <= cfg_close_step_delay;
        end
    end

    brcs_step u_step (
        .cur_state        (state_reg),
        .close_step_delay (close_step_delay_reg),
        .fault_present    (s_fault_present),
        .close_request    (s_close_request),
        .next_state       (state_next)
    );

    // Advance the sequencer state once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_OPEN, close_step: STEP_NONE,
                           delay_count: '0, enables: '0};
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register: holds the post-tick outputs until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_enables_reg <= state_next.enables;
            m_mode_reg    <= state_next.mode;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_positive_enable = m_enables_reg[0];
    assign m_negative_enable = m_enables_reg[1];
    assign m_solar_enable    = m_enables_reg[2];
    assign m_relay_mode      = m_mode_reg;

    // Fault mode never releases.
    `BRCS_ASSERT_NXT(a_fault_sticky, state_reg.mode == MODE_FAULT, state_reg.mode == MODE_FAULT)
    // Relays are only driven in closed mode.
    `BRCS_ASSERT_IMP(a_enables_closed_only, state_reg.enables != '0, state_reg.mode == MODE_CLOSED)
    // Relays close strictly in order positive, negative, solar.
    `BRCS_ASSERT_IMP(a_close_order, state_reg.enables[2], state_reg.enables[1] && state_reg.enables[0])
    // Nothing pending once the last relay has closed.
    `BRCS_ASSERT_IMP(a_done_idle, state_reg.close_step == STEP_SOLAR, state_reg.delay_count == '0)
    // A held result is not overwritten while stalled.
    `BRCS_ASSERT_IMP(a_no_overrun, m_valid_reg && !m_ready, !s_accept)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the battery relay close sequencer unit.
module tb_top;
    import brcs_pkg::*;

    // Give up well past the slowest legal run: every item behind a full
    // sender gap and a full receiver stall, plus the long receiver hold.
    localparam int CYCLE_LIMIT = 300000;

    // One tick offered on the input channel.
    typedef struct packed {
        logic fault;
        logic close;
    } relay_tick_t;

    // Relay drive levels and mode reported for one tick.
    typedef struct packed {
        logic              pos_en;
        logic              neg_en;
        logic              sol_en;
        logic [MODE_W-1:0] mode;
    } relay_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [DELAY_W-1:0] cfg_close_step_delay = '0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_fault_present = 1'b0;
    logic s_close_request = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_positive_enable;
    logic              m_negative_enable;
    logic              m_solar_enable;
    logic [MODE_W-1:0] m_relay_mode;

    battery_relay_close_sequencer_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_close_step_delay (cfg_close_step_delay),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_fault_present      (s_fault_present),
        .s_close_request      (s_close_request),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_positive_enable    (m_positive_enable),
        .m_negative_enable    (m_negative_enable),
        .m_solar_enable       (m_solar_enable),
        .m_relay_mode         (m_relay_mode)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: the sequencer's registers and its delay setting.
    brcs_state_t        relay_st = '{mode: MODE_OPEN, close_step: STEP_NONE,
                                     delay_count: '0, enables: '0};
    logic [DELAY_W-1:0] close_delay = CLOSE_STEP_DELAY_RESET;

    relay_tick_t ticks_to_send[$];
    relay_out_t  relay_outs_due[$];

    int  ticks_offered  = 0;
    int  ticks_accepted = 0;
    int  results_seen   = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    bit  idle_on        = 1'b1;
    bit  src_pause      = 1'b0;
    int  src_gap        = 0;
    int  snk_hold       = 0;
    bit  long_hold_done = 1'b0;

    // Count a zero setting as one tick, like the hardware does.
    function automatic logic [DELAY_W-1:0] step_reload();
        return (close_delay == '0) ? DELAY_W'(1) : close_delay;
    endfunction

    // Advance the predictor by one tick and return the drive levels after it.
    function automatic relay_out_t advance_relay_tick(input logic fault, input logic close);
        relay_out_t res;
        if (relay_st.mode == MODE_FAULT || fault) begin
            // Fault wins over everything and never lets go.
            relay_st.mode        = MODE_FAULT;
            relay_st.enables     = '0;
            relay_st.close_step  = STEP_NONE;
            relay_st.delay_count = '0;
        end else if (relay_st.mode == MODE_OPEN) begin
            if (close) begin
                relay_st.mode        = MODE_CLOSED;
                relay_st.close_step  = STEP_NONE;
                relay_st.delay_count = step_reload();
            end
        end else if (!close) begin
            // Open drops every relay and cancels the pending step.
            relay_st.mode        = MODE_OPEN;
            relay_st.enables     = '0;
            relay_st.close_step  = STEP_NONE;
            relay_st.delay_count = '0;
        end else if (relay_st.delay_count != '0) begin
            relay_st.delay_count = relay_st.delay_count - DELAY_W'(1);
            if (relay_st.delay_count == '0) begin
                case (relay_st.close_step)
                    STEP_NONE: begin
                        relay_st.enables     = relay_st.enables | EN_POSITIVE;
                        relay_st.close_step  = STEP_POSITIVE;
                        relay_st.delay_count = step_reload();
                    end
                    STEP_POSITIVE: begin
                        relay_st.enables     = relay_st.enables | EN_NEGATIVE;
                        relay_st.close_step  = STEP_NEGATIVE;
                        relay_st.delay_count = step_reload();
                    end
                    STEP_NEGATIVE: begin
                        relay_st.enables     = relay_st.enables | EN_SOLAR;
                        relay_st.close_step  = STEP_SOLAR;
                        relay_st.delay_count = '0;
                    end
                    default: begin
                        relay_st.delay_count = '0;
                    end
                endcase
            end
        end
        res.pos_en = |(relay_st.enables & EN_POSITIVE);
        res.neg_en = |(relay_st.enables & EN_NEGATIVE);
        res.sol_en = |(relay_st.enables & EN_SOLAR);
        res.mode   = relay_st.mode;
        return res;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            error_count++;
        end
    endfunction

    function automatic void queue_tick(input logic fault, input logic close);
        relay_tick_t t;
        t.fault = fault;
        t.close = close;
        ticks_to_send.push_back(t);
    endfunction

    // Input driver: present the next queued tick at the falling edge and hold
    // it until accepted; insert random gap bursts while idling is on.
    always @(negedge aclk) begin
        relay_tick_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (ticks_offered != ticks_accepted) begin
            // hold the current item until the handshake completes
        end else if (src_gap > 0) begin
            src_gap--;
            s_valid <= 1'b0;
        end else if (src_pause || ticks_to_send.size() == 0) begin
            s_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(1, 17) - 1;
            s_valid <= 1'b0;
        end else begin
            t = ticks_to_send.pop_front();
            s_valid         <= 1'b1;
            s_fault_present <= t.fault;
            s_close_request <= t.close;
            ticks_offered++;
        end
    end

    // Result sink: random stall bursts, plus one long hold-off once a few
    // hundred results have passed and the sender still has plenty queued,
    // so the result register fills and the input channel backs up while
    // the driver keeps offering.
    always @(negedge aclk) begin
        if (snk_hold > 0) begin
            snk_hold--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 300 && ticks_to_send.size() > 20) begin
            long_hold_done = 1'b1;
            snk_hold = 79;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            snk_hold = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: track register writes, predict each accepted tick, and check
    // each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        relay_out_t due;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                close_delay = cfg_close_step_delay;
            if (s_valid && s_ready) begin
                relay_outs_due.push_back(advance_relay_tick(s_fault_present,
                                                            s_close_request));
                ticks_accepted++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (relay_outs_due.size() == 0) begin
                    $error("relay result arrived with no tick outstanding");
                    error_count++;
                end else begin
                    due = relay_outs_due.pop_front();
                    check_field("positive_enable", int'(due.pos_en),
                                int'(m_positive_enable));
                    check_field("negative_enable", int'(due.neg_en),
                                int'(m_negative_enable));
                    check_field("solar_enable", int'(due.sol_en), int'(m_solar_enable));
                    check_field("relay_mode", int'(due.mode), int'(m_relay_mode));
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("battery_relay_close_sequencer_unit test failed");
            $finish;
        end
    end

    // Wait until every queued tick is sent and every result has come back.
    task automatic wait_all_settled();
        while (ticks_to_send.size() != 0 || ticks_offered != ticks_accepted ||
               relay_outs_due.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_close_delay(input logic [DELAY_W-1:0] value);
        @(negedge aclk);
        cfg_valid            <= 1'b1;
        cfg_close_step_delay <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Build one random phase: mostly close-then-open sequences of random length, up
    // to long enough to reach every relay step at delay d, with some loose noise ticks.
    task automatic fill_random_phase(input int d, input int n);
        int added;
        int len;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(0, 3 * d + 4);
                repeat (len) queue_tick(1'b0, 1'b1);
                added += len;
                len = $urandom_range(1, 3);
                repeat (len) queue_tick(1'b0, 1'b0);
                added += len;
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) queue_tick(1'b0, 1'($urandom_range(0, 1)));
                added += len;
            end
        end
    endtask

    initial begin
        int d;
        // Hold reset, then release it at a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset delay of 150: close long enough for the positive relay,
        // then open twice to check a repeated open.
        repeat (153) queue_tick(1'b0, 1'b1);
        repeat (2) queue_tick(1'b0, 1'b0);
        wait_all_settled();

        // Zero delay acts as one: all three relays in consecutive ticks,
        // repeated close, repeated open, and an open that cancels a step.
        write_close_delay('0);
        repeat (5) queue_tick(1'b0, 1'b1);
        repeat (2) queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        wait_all_settled();

        // Maximum delay, then change the setting with a step still pending:
        // the running count keeps going, only the next load sees the change.
        write_close_delay('1);
        repeat (5) queue_tick(1'b0, 1'b1);
        wait_all_settled();
        write_close_delay(DELAY_W'(2));
        repeat (4) queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        repeat (6) queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        wait_all_settled();

        // Random phases at several small delays.
        for (int p = 0; p < 8; p++) begin
            d = (p == 0) ? 1 : (p == 5) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            write_close_delay(DELAY_W'(d));
            fill_random_phase(d, 52);
            if (p == 3) begin
                // Pause the sender mid-phase until every result is back.
                while (ticks_to_send.size() > 25) @(posedge aclk);
                src_pause = 1'b1;
                while (ticks_offered != ticks_accepted || relay_outs_due.size() != 0)
                    @(posedge aclk);
                src_pause = 1'b0;
            end
            wait_all_settled();
        end

        // Last part, no idling: close partway, then a fault while closed,
        // then random ticks that must all stay in fault mode.
        idle_on = 1'b0;
        write_close_delay(DELAY_W'(3));
        repeat (8) queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        repeat (20) queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_all_settled();
        write_close_delay(DELAY_W'(1));
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        repeat (10) queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_all_settled();

        if (error_count == 0)
            $display("battery_relay_close_sequencer_unit test passed");
        else
            $display("battery_relay_close_sequencer_unit test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/brcs_pkg.sv
hw/rtl/brcs_step.sv
hw/rtl/battery_relay_close_sequencer_unit.sv
tb/tb_top.sv
